@@ rtl/eip_pkg.sv @@
`timescale 1ns / 1ps
package eip_pkg;
	localparam int MAX_FRAME_BYTES_DEF = 2048;

	localparam logic [3:0] ERR_OK        = 4'd0;
	localparam logic [3:0] ERR_ETH_SHORT = 4'd1;
	localparam logic [3:0] ERR_VLAN      = 4'd2;
	localparam logic [3:0] ERR_IP4_SHORT = 4'd3;
	localparam logic [3:0] ERR_IHL       = 4'd4;
	localparam logic [3:0] ERR_IP4_TRUNC = 4'd5;
	localparam logic [3:0] ERR_TOT       = 4'd6;
	localparam logic [3:0] ERR_TCP_SHORT = 4'd7;
	localparam logic [3:0] ERR_TCP_OFF   = 4'd8;
	localparam logic [3:0] ERR_UDP_SHORT = 4'd9;
	localparam logic [3:0] ERR_UDP_LEN   = 4'd10;
	localparam logic [3:0] ERR_ETYPE     = 4'd11;
	localparam logic [3:0] ERR_TOO_LONG  = 4'd12;

	localparam logic [0:0] REG_VLAN = 1'd0;
	localparam logic [0:0] REG_FRAG = 1'd1;

	typedef enum logic [2:0] {
		PH_ETH, PH_VLAN, PH_IPV4, PH_IPV6, PH_OTHER
	} phase_t;

	// Length, offsets, phase and IP/L4 header fields captured from one frame, handed to the finishing logic.
	typedef struct packed {
		logic [15:0] len;
		logic [15:0] l3_off;
		phase_t      phase;
		logic [5:0]  ihl;
		logic [15:0] tot;
		logic [15:0] frag;
		logic [7:0]  proto;
		logic [3:0]  ver;
		logic        too_long;
		logic [15:0] l4len;
	} frame_sum_t;

	typedef struct packed {
		logic [3:0]  err;
		logic [1:0]  l3;
		logic [1:0]  l4;
		logic        frag;
		logic        elig;
		logic [11:0] pstart;
		logic [11:0] plen;
	} verdict_t;
endpackage

@@ rtl/eip_finish.sv @@
`timescale 1ns / 1ps
module eip_finish (
	input  eip_pkg::frame_sum_t sum,
	input  logic                skip_frag,
	output eip_pkg::verdict_t   res
);
	logic [16:0] len, o, l4s, ipend, thl, po6;
	logic [16:0] ul;
	logic [3:0]  err_code;

	always_comb begin
		len   = {1'b0, sum.len};
		o     = {1'b0, sum.l3_off};
		l4s   = o + {11'd0, sum.ihl};
		ipend = o + {1'b0, sum.tot};
		thl   = {11'd0, sum.l4len[7:4], 2'b00};
		ul    = {1'b0, sum.l4len};
		po6   = o + 17'd40 + thl;
		res   = '0;
		res.elig = 1'b1;
		if (sum.too_long) res.err = eip_pkg::ERR_TOO_LONG;
		else begin
			case (sum.phase)
				eip_pkg::PH_ETH:   res.err = eip_pkg::ERR_ETH_SHORT;
				eip_pkg::PH_VLAN:  res.err = eip_pkg::ERR_VLAN;
				eip_pkg::PH_IPV4: begin
					if (len < o + 17'd20 || sum.ver != 4'd4) res.err = eip_pkg::ERR_IP4_SHORT;
					else if (sum.ihl < 6'd20) res.err = eip_pkg::ERR_IHL;
					else if (l4s > len) res.err = eip_pkg::ERR_IP4_TRUNC;
					else if (sum.tot < {10'd0, sum.ihl}) res.err = eip_pkg::ERR_TOT;
					else if (ipend > len) res.err = eip_pkg::ERR_IP4_TRUNC;
					else begin
						res.l3 = 2'd1;
						if (sum.frag[13:0] != 14'd0) begin
							res.frag = 1'b1;
							res.elig = !skip_frag;
						end
						if (sum.proto == 8'd6) begin
							if (l4s + 17'd20 > ipend) res.err = eip_pkg::ERR_TCP_SHORT;
							else if (thl < 17'd20) res.err = eip_pkg::ERR_TCP_OFF;
							else if (l4s + thl > ipend) res.err = eip_pkg::ERR_TCP_SHORT;
							else begin
								res.l4 = 2'd1;
								res.pstart = 12'(l4s + thl);
								res.plen = 12'(ipend - l4s - thl);
							end
						end else if (sum.proto == 8'd17) begin
							if (l4s + 17'd8 > ipend) res.err = eip_pkg::ERR_UDP_SHORT;
							else if (ul < 17'd8) res.err = eip_pkg::ERR_UDP_LEN;
							else if (l4s + ul > ipend) res.err = eip_pkg::ERR_UDP_LEN;
							else begin
								res.l4 = 2'd2;
								res.pstart = 12'(l4s + 17'd8);
								res.plen = 12'(ul - 17'd8);
							end
						end
					end
				end
				eip_pkg::PH_IPV6: begin
					if (len < o + 17'd40) res.err = eip_pkg::ERR_ETH_SHORT;
					else begin
						res.l3 = 2'd2;
						if (sum.proto == 8'd6 && len >= o + 17'd60) begin
							res.l4 = 2'd1;
							if (po6 <= len) begin
								res.pstart = 12'(po6);
								res.plen = 12'(len - po6);
							end
						end else if (sum.proto == 8'd17 && len >= o + 17'd48) begin
							res.l4 = 2'd2;
							res.pstart = 12'(o + 17'd48);
							res.plen = 12'(len - o - 17'd48);
						end
					end
				end
				default: res.err = eip_pkg::ERR_ETYPE;
			endcase
		end
		err_code = res.err;
		if (err_code != eip_pkg::ERR_OK) begin
			res = '0;
			res.err = err_code;
		end
	end
endmodule

@@ rtl/eth_ip_l4_header_parser_core.sv @@
`timescale 1ns / 1ps
// Channel | Dir | Handshake     | Word
// in      | in  | valid / stall | data_byte, last_byte
// out     | out | valid / stall | error_code .. last_word
// cfg     | in  | valid / ready | cfg_index, cfg_data
// One byte is taken per cycle unless in_stall holds it; captures update as each byte passes.
// The last byte registers a frame summary; checks run in the next cycle
// and five words (or one error word) leave from a result queue of depth 5.
// A new frame may start while that queue drains; the input stalls only when
// a last byte would overrun a pending summary or words still queued.
// arst_n clears control state and the configuration to its reset values.
module eth_ip_l4_header_parser_core #(
	parameter int MAX_FRAME_BYTES = eip_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  error_code,
	output logic [1:0]  l3_kind,
	output logic [1:0]  l4_kind,
	output logic        fragmented,
	output logic        inspect_ok,
	output logic [7:0]  tcp_flag_bits,
	output logic [15:0] source_port,
	output logic [15:0] destination_port,
	output logic [11:0] payload_offset,
	output logic [11:0] payload_bytes,
	output logic [63:0] word_value,
	output logic        last_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic        cfg_data
);
	localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

	logic vlan_en_q, skip_frag_q;
	logic [CW-1:0] cnt_q;
	eip_pkg::phase_t phase_q;
	logic [15:0] etype_q, l3off_q, tot_q, fragw_q, l4len_q;
	logic [5:0]  ihl_q;
	logic [3:0]  ver_q;
	logic [7:0]  proto_q, flags_q;
	logic [63:0] src_q [2], dst_q [2];
	logic [15:0] port_q [2];
	logic [63:0] seq_q;
	logic        tl_q;

	// Finished frame, held in the register ahead of the output queue.
	logic        v_s1;
	eip_pkg::frame_sum_t sum_s1;
	logic [63:0] src_s1 [2], dst_s1 [2], seq_s1;
	logic [15:0] port_s1 [2];
	logic [7:0]  flags_s1;

	eip_pkg::verdict_t vd;
	logic [2:0] left_q, idx_q;
	eip_pkg::verdict_t vd_q;
	logic [63:0] w_q [5];
	logic [15:0] sp_q, dp_q;
	logic [7:0]  tf_q;

	logic acc, fin, take;
	assign cfg_ready = 1'b1;
	assign take = out_valid && !out_stall;
	// Hold off a last byte while a summary, more than one word, or an untaken last word is pending.
	assign in_stall = last_byte && (v_s1 || (left_q > 3'd1) || (left_q == 3'd1 && !take));
	assign acc = in_valid && !in_stall;
	assign fin = acc && last_byte;

	eip_pkg::frame_sum_t cur;
	logic [15:0] c16, r;
	logic [CW:0] cnt_ext;
	logic [4:0] q;
	logic l4_hit;

	// Next-state of the capture registers for the current byte.
	logic [15:0] n_etype, n_l3off, n_tot, n_fragw, n_l4len;
	logic [5:0]  n_ihl;
	logic [3:0]  n_ver;
	logic [7:0]  n_proto, n_flags;
	logic [63:0] n_src [2], n_dst [2], n_seq;
	logic [15:0] n_port [2];
	eip_pkg::phase_t n_phase;
	logic n_tl;
	logic [CW-1:0] n_cnt;

	function automatic eip_pkg::phase_t pick(input logic [15:0] et, input logic ven);
		if (ven && (et == 16'h8100 || et == 16'h88A8)) return eip_pkg::PH_VLAN;
		else if (et == 16'h0800) return eip_pkg::PH_IPV4;
		else if (et == 16'h86DD) return eip_pkg::PH_IPV6;
		return eip_pkg::PH_OTHER;
	endfunction

	always_comb begin
		cnt_ext = {1'b0, cnt_q};
		c16 = 16'(cnt_q);
		r = c16 - l3off_q;
		n_etype = etype_q; n_l3off = l3off_q; n_tot = tot_q; n_fragw = fragw_q;
		n_l4len = l4len_q; n_ihl = ihl_q; n_ver = ver_q; n_proto = proto_q;
		n_flags = flags_q; n_src = src_q; n_dst = dst_q; n_seq = seq_q;
		n_port = port_q; n_phase = phase_q; n_tl = tl_q; n_cnt = cnt_q;
		q = '0; l4_hit = 1'b0;
		if (cnt_ext >= (CW+1)'(MAX_FRAME_BYTES)) n_tl = 1'b1;
		else begin
			n_cnt = cnt_q + 1'b1;
			case (phase_q)
				eip_pkg::PH_ETH: begin
					if (c16 == 16'd12 || c16 == 16'd13) n_etype = {etype_q[7:0], data_byte};
					if (c16 == 16'd13) n_phase = pick({etype_q[7:0], data_byte}, vlan_en_q);
				end
				eip_pkg::PH_VLAN: begin
					if (r == 16'd2 || r == 16'd3) n_etype = {etype_q[7:0], data_byte};
					if (r == 16'd3) begin
						n_l3off = l3off_q + 16'd4;
						n_phase = pick({etype_q[7:0], data_byte}, vlan_en_q);
					end
				end
				eip_pkg::PH_IPV4: begin
					if (r == 16'd0) begin
						n_ver = data_byte[7:4];
						n_ihl = {data_byte[3:0], 2'b00};
					end else if (r == 16'd2 || r == 16'd3) n_tot = {tot_q[7:0], data_byte};
					else if (r == 16'd6 || r == 16'd7) n_fragw = {fragw_q[7:0], data_byte};
					else if (r == 16'd9) n_proto = data_byte;
					else if (r >= 16'd12 && r < 16'd16)
						n_src[1] = {32'd0, src_q[1][23:0], data_byte};
					else if (r >= 16'd16 && r < 16'd20)
						n_dst[1] = {32'd0, dst_q[1][23:0], data_byte};
					if (ihl_q >= 6'd20 && r >= {10'd0, ihl_q} && r - {10'd0, ihl_q} < 16'd20) begin
						l4_hit = 1'b1;
						q = 5'(r - {10'd0, ihl_q});
					end
				end
				eip_pkg::PH_IPV6: begin
					if (r == 16'd6) n_proto = data_byte;
					else if (r >= 16'd8 && r < 16'd16) n_src[0] = {src_q[0][55:0], data_byte};
					else if (r >= 16'd16 && r < 16'd24) n_src[1] = {src_q[1][55:0], data_byte};
					else if (r >= 16'd24 && r < 16'd32) n_dst[0] = {dst_q[0][55:0], data_byte};
					else if (r >= 16'd32 && r < 16'd40) n_dst[1] = {dst_q[1][55:0], data_byte};
					else if (r >= 16'd40 && r < 16'd60) begin
						l4_hit = 1'b1;
						q = 5'(r - 16'd40);
					end
				end
				default: ;
			endcase
			if (l4_hit) begin
				if (q < 5'd2) n_port[0] = {port_q[0][7:0], data_byte};
				else if (q < 5'd4) n_port[1] = {port_q[1][7:0], data_byte};
				else if (q < 5'd12) n_seq = {seq_q[55:0], data_byte};
				if ((q == 5'd4 || q == 5'd5) && proto_q == 8'd17) n_l4len = {l4len_q[7:0], data_byte};
				if (q == 5'd12 && proto_q == 8'd6) n_l4len = {8'd0, data_byte};
				if (q == 5'd13) n_flags = data_byte;
			end
		end
		cur.len = 16'(n_cnt); cur.l3_off = n_l3off; cur.phase = n_phase; cur.ihl = n_ihl;
		cur.tot = n_tot; cur.frag = n_fragw; cur.proto = n_proto; cur.ver = n_ver;
		cur.too_long = n_tl; cur.l4len = n_l4len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlan_en_q <= 1'b1; skip_frag_q <= 1'b0;
			cnt_q <= '0; phase_q <= eip_pkg::PH_ETH; etype_q <= '0; l3off_q <= 16'd14;
			tot_q <= '0; fragw_q <= '0; l4len_q <= '0; ihl_q <= '0; ver_q <= '0;
			proto_q <= '0; flags_q <= '0; seq_q <= '0; tl_q <= 1'b0;
			src_q <= '{default: '0}; dst_q <= '{default: '0}; port_q <= '{default: '0};
			v_s1 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == eip_pkg::REG_VLAN) vlan_en_q <= cfg_data;
				else skip_frag_q <= cfg_data;
			end
			v_s1 <= fin;
			if (fin) begin
				cnt_q <= '0; phase_q <= eip_pkg::PH_ETH; etype_q <= '0; l3off_q <= 16'd14;
				tot_q <= '0; fragw_q <= '0; l4len_q <= '0; ihl_q <= '0; ver_q <= '0;
				proto_q <= '0; flags_q <= '0; seq_q <= '0; tl_q <= 1'b0;
				src_q <= '{default: '0}; dst_q <= '{default: '0}; port_q <= '{default: '0};
			end else if (acc) begin
				cnt_q <= n_cnt; phase_q <= n_phase; etype_q <= n_etype; l3off_q <= n_l3off;
				tot_q <= n_tot; fragw_q <= n_fragw; l4len_q <= n_l4len; ihl_q <= n_ihl;
				ver_q <= n_ver; proto_q <= n_proto; flags_q <= n_flags; seq_q <= n_seq;
				tl_q <= n_tl; src_q <= n_src; dst_q <= n_dst; port_q <= n_port;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			sum_s1 <= cur; src_s1 <= n_src; dst_s1 <= n_dst; seq_s1 <= n_seq;
			port_s1 <= n_port; flags_s1 <= n_flags;
		end
	end

	eip_finish u_finish (.sum(sum_s1), .skip_frag(skip_frag_q), .res(vd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0; idx_q <= '0;
		end else if (v_s1) begin
			left_q <= (vd.err != eip_pkg::ERR_OK) ? 3'd1 : 3'd5;
			idx_q <= (vd.err != eip_pkg::ERR_OK) ? 3'd4 : 3'd0;
		end else if (take) begin
			left_q <= left_q - 3'd1;
			idx_q <= idx_q + 3'd1;
		end
	end

	logic tcp4;
	assign tcp4 = vd.l3 == 2'd1 && vd.l4 == 2'd1;
	always_ff @(posedge clk) begin
		if (v_s1) begin
			vd_q <= vd;
			w_q[0] <= src_s1[0]; w_q[1] <= src_s1[1];
			w_q[2] <= dst_s1[0]; w_q[3] <= dst_s1[1];
			w_q[4] <= (vd.err != eip_pkg::ERR_OK || !tcp4) ? 64'd0 : seq_s1;
			tf_q <= tcp4 ? flags_s1 : 8'd0;
			sp_q <= (vd.l4 != 2'd0) ? port_s1[0] : 16'd0;
			dp_q <= (vd.l4 != 2'd0) ? port_s1[1] : 16'd0;
		end
	end

	assign out_valid = left_q != 3'd0;
	assign error_code = vd_q.err;
	assign l3_kind = vd_q.l3;
	assign l4_kind = vd_q.l4;
	assign fragmented = vd_q.frag;
	assign inspect_ok = vd_q.elig;
	assign tcp_flag_bits = tf_q;
	assign source_port = sp_q;
	assign destination_port = dp_q;
	assign payload_offset = vd_q.pstart;
	assign payload_bytes = vd_q.plen;
	assign word_value = w_q[idx_q];
	assign last_word = idx_q == 3'd4;
endmodule

@@ rtl/eth_ip_l4_header_parser_core_chk.sv @@
`timescale 1ns / 1ps
module eth_ip_l4_header_parser_core_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] error_code,
	input logic       last_word,
	input logic [63:0] word_value,
	input logic [1:0] l3_kind
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(word_value)) else $error("word dropped");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != eip_pkg::ERR_OK |-> last_word) else $error("error not single");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != eip_pkg::ERR_OK |-> l3_kind == 2'd0 && word_value == 64'd0)
		else $error("error fields");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code <= eip_pkg::ERR_TOO_LONG) else $error("bad code");
endmodule

bind eth_ip_l4_header_parser_core eth_ip_l4_header_parser_core_chk u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.error_code(error_code), .last_word(last_word), .word_value(word_value),
	.l3_kind(l3_kind)
);
